// ===== src/iouct_pkg.sv =====
// ----------------------------------------------------------------------------
// iouct_pkg
// Types and constants shared by the track matcher modules.
// ----------------------------------------------------------------------------
package iouct_pkg;

	localparam int COORD_W = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVL_WEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROX_WEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT = 2'd3;

	localparam logic [15:0] RST_MATCH_THR = 16'd13107;
	localparam logic [15:0] RST_OVL_WEIGHT = 16'd22938;
	localparam logic [15:0] RST_PROX_WEIGHT = 16'd9830;
	localparam logic [7:0] RST_LOST_LIMIT = 8'd8;

	typedef struct packed {
		logic               req_type;
		logic [COORD_W-1:0] box_x;
		logic [COORD_W-1:0] box_y;
		logic [COORD_W-1:0] box_w;
		logic [COORD_W-1:0] box_h;
		logic [3:0]         object_class;
	} req_t;

	typedef struct packed {
		logic [15:0] track_number;
		logic        is_new;
		logic        was_stored;
		logic [6:0]  removed_count;
	} rsp_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
	} box_t;

	typedef struct packed {
		logic [15:0] track_number;
		logic [3:0]  cls;
		box_t        box;
		logic [7:0]  lost;
	} slot_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DCHK,
		ST_DCLS,
		ST_DGEO,
		ST_DINIT,
		ST_ITA,
		ST_ITB,
		ST_ITC,
		ST_SC1,
		ST_SC2,
		ST_DWR,
		ST_ACHK,
		ST_AUPD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load_item;
		logic scan_start;
		logic rd;
		logic skip_free;
		logic next;
		logic geo1;
		logic geo2;
		logic srch_init;
		logic mul1;
		logic mul2;
		logic decide;
		logic sc1;
		logic sc2;
		logic commit;
		logic age_upd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic slot_valid;
		logic slot_last;
		logic class_hit;
		logic iter_last;
		logic out_free;
	} stat_t;

endpackage

// ===== src/iou_centroid_track_matcher_core.sv =====
// ----------------------------------------------------------------------------
// iou_centroid_track_matcher_core
// Multi-object track matcher, overlap plus center-proximity scoring.
// ----------------------------------------------------------------------------
// One request at a time; each gives one response. A detection walks all
// MAX_TRACKS slots: an empty slot is only checked, an occupied slot of
// another class is read and its class compared, and an occupied slot of the
// same class is scored; then the match is committed and the response sent.
// Same-class scoring runs the 16-trial proximity search (one 31x29 multiply
// each) with the overlap divider running alongside. End of frame reads and
// ages each occupied slot and skips empty ones. The slot table is one RAM
// with a registered read; valid bits are flops and clear at reset.
module iou_centroid_track_matcher_core #(
	parameter int MAX_TRACKS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  iouct_pkg::req_t                   req_data,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output iouct_pkg::rsp_t                   rsp_data,
	input  logic                              cfg_we,
	input  logic [iouct_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [iouct_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	iouct_pkg::cmd_t  cmd;
	iouct_pkg::stat_t stat;

	iouct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_type (req_data.req_type),
		.req_ready(req_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	iouct_dp #(
		.MAX_TRACKS(MAX_TRACKS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

endmodule

// ===== src/iouct_ram.sv =====
// ----------------------------------------------------------------------------
// iouct_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module iouct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/iouct_ctrl.sv =====
// ----------------------------------------------------------------------------
// iouct_ctrl
// Sequencer: walks the slot table for a detection or an end-of-frame request.
// ----------------------------------------------------------------------------
module iouct_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_type,
	output logic            req_ready,
	input  iouct_pkg::stat_t stat,
	output iouct_pkg::cmd_t  cmd
);

	iouct_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iouct_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iouct_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = req_type ? iouct_pkg::ST_ACHK : iouct_pkg::ST_DCHK;
				end
			end
			iouct_pkg::ST_DCHK: begin
				if (stat.slot_valid) begin
					state_d = iouct_pkg::ST_DCLS;
				end else if (stat.slot_last) begin
					state_d = iouct_pkg::ST_DWR;
				end
			end
			iouct_pkg::ST_DCLS: begin
				if (stat.class_hit) begin
					state_d = iouct_pkg::ST_DGEO;
				end else begin
					state_d = stat.slot_last ? iouct_pkg::ST_DWR : iouct_pkg::ST_DCHK;
				end
			end
			iouct_pkg::ST_DGEO:  state_d = iouct_pkg::ST_DINIT;
			iouct_pkg::ST_DINIT: state_d = iouct_pkg::ST_ITA;
			iouct_pkg::ST_ITA:   state_d = iouct_pkg::ST_ITB;
			iouct_pkg::ST_ITB:   state_d = iouct_pkg::ST_ITC;
			iouct_pkg::ST_ITC: begin
				state_d = stat.iter_last ? iouct_pkg::ST_SC1 : iouct_pkg::ST_ITA;
			end
			iouct_pkg::ST_SC1:   state_d = iouct_pkg::ST_SC2;
			iouct_pkg::ST_SC2: begin
				state_d = stat.slot_last ? iouct_pkg::ST_DWR : iouct_pkg::ST_DCHK;
			end
			iouct_pkg::ST_DWR:   state_d = iouct_pkg::ST_FIN;
			iouct_pkg::ST_ACHK: begin
				if (stat.slot_valid) begin
					state_d = iouct_pkg::ST_AUPD;
				end else if (stat.slot_last) begin
					state_d = iouct_pkg::ST_FIN;
				end
			end
			iouct_pkg::ST_AUPD: begin
				state_d = stat.slot_last ? iouct_pkg::ST_FIN : iouct_pkg::ST_ACHK;
			end
			iouct_pkg::ST_FIN: begin
				if (stat.out_free) begin
					state_d = iouct_pkg::ST_IDLE;
				end
			end
			default: state_d = iouct_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		unique case (state_q)
			iouct_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_item = 1'b1;
					cmd.scan_start = 1'b1;
				end
			end
			iouct_pkg::ST_DCHK: begin
				if (stat.slot_valid) begin
					cmd.rd = 1'b1;
				end else begin
					cmd.skip_free = 1'b1;
					cmd.next = !stat.slot_last;
				end
			end
			iouct_pkg::ST_DCLS: begin
				if (stat.class_hit) begin
					cmd.geo1 = 1'b1;
				end else begin
					cmd.next = !stat.slot_last;
				end
			end
			iouct_pkg::ST_DGEO:  cmd.geo2 = 1'b1;
			iouct_pkg::ST_DINIT: cmd.srch_init = 1'b1;
			iouct_pkg::ST_ITA:   cmd.mul1 = 1'b1;
			iouct_pkg::ST_ITB:   cmd.mul2 = 1'b1;
			iouct_pkg::ST_ITC:   cmd.decide = 1'b1;
			iouct_pkg::ST_SC1:   cmd.sc1 = 1'b1;
			iouct_pkg::ST_SC2: begin
				cmd.sc2 = 1'b1;
				cmd.next = !stat.slot_last;
			end
			iouct_pkg::ST_DWR:   cmd.commit = 1'b1;
			iouct_pkg::ST_ACHK: begin
				if (stat.slot_valid) begin
					cmd.rd = 1'b1;
				end else begin
					cmd.next = !stat.slot_last;
				end
			end
			iouct_pkg::ST_AUPD: begin
				cmd.age_upd = 1'b1;
				cmd.next = !stat.slot_last;
			end
			iouct_pkg::ST_FIN:   cmd.out_load = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== src/iouct_dp.sv =====
// ----------------------------------------------------------------------------
// iouct_dp
// Datapath: slot table, geometry, overlap divider, proximity search, scoring.
// ----------------------------------------------------------------------------
module iouct_dp #(
	parameter int MAX_TRACKS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  iouct_pkg::req_t                      req_data,
	input  logic                                 cfg_we,
	input  logic [iouct_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [iouct_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  iouct_pkg::cmd_t                      cmd,
	output iouct_pkg::stat_t                     stat,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output iouct_pkg::rsp_t                      rsp_data
);

	localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int CW = iouct_pkg::COORD_W;
	localparam int EW = CW + 1;
	localparam int DW = CW + 2;
	localparam int SW = $bits(iouct_pkg::slot_t);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TRACKS - 1);

	// configuration
	logic [15:0] thr_q, ow_q, pw_q;
	logic [7:0]  limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= iouct_pkg::RST_MATCH_THR;
			ow_q    <= iouct_pkg::RST_OVL_WEIGHT;
			pw_q    <= iouct_pkg::RST_PROX_WEIGHT;
			limit_q <= iouct_pkg::RST_LOST_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				iouct_pkg::CFG_MATCH_THR:   thr_q <= cfg_wdata;
				iouct_pkg::CFG_OVL_WEIGHT:  ow_q <= cfg_wdata;
				iouct_pkg::CFG_PROX_WEIGHT: pw_q <= cfg_wdata;
				iouct_pkg::CFG_LOST_LIMIT:  limit_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// slot table
	iouct_pkg::req_t  item_q;
	logic [IDX_W-1:0] idx_q;
	logic [MAX_TRACKS-1:0] valid_q;
	logic [15:0]      next_id_q;
	iouct_pkg::slot_t rd_slot;
	logic [SW-1:0]    rd_word;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	iouct_pkg::slot_t wr_slot;

	iouct_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_TRACKS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_slot),
		.re   (cmd.rd),
		.raddr(idx_q),
		.rdata(rd_word)
	);

	assign rd_slot = iouct_pkg::slot_t'(rd_word);

	// scan bookkeeping
	logic             found_q, free_found_q;
	logic [IDX_W-1:0] best_idx_q, free_idx_q;
	logic [17:0]      best_q;
	logic [15:0]      best_tn_q, cand_tn_q;
	logic [6:0]       removed_q;
	iouct_pkg::rsp_t  res_q;

	// geometry and search registers
	logic [EW-1:0]   iw_q, ih_q, bw_q, bh_q;
	logic [DW-1:0]   dx_q, dy_q;
	logic [2*EW-1:0] inter_q, bound_q;
	logic [2*DW-1:0] dxsq_q, dysq_q;
	logic [2*DW:0]   s_q;
	logic [2*EW:0]   rem_q;
	logic [15:0]     ov_q, p_q;
	logic [3:0]      bit_q;
	logic            ok_q;
	logic [31:0]     psq_q;
	logic [33:0]     rsq_q;
	logic [59:0]     prod_q;
	logic [31:0]     ovp_q, pxp_q;

	// geometry of the request box against the slot box
	logic [EW-1:0] ax, ay, aex, aey, bx, by, bex, bey;
	logic [EW-1:0] x1, x2, y1, y2, lx, ly, rx, ry, iw, ih, bwd, bhd;
	logic [DW-1:0] ca, cb, da, db;
	logic          a_empty, b_empty;

	always_comb begin
		ax  = {1'b0, item_q.box_x};
		ay  = {1'b0, item_q.box_y};
		aex = ax + {1'b0, item_q.box_w};
		aey = ay + {1'b0, item_q.box_h};
		bx  = {1'b0, rd_slot.box.x};
		by  = {1'b0, rd_slot.box.y};
		bex = bx + {1'b0, rd_slot.box.w};
		bey = by + {1'b0, rd_slot.box.h};
		x1 = (ax > bx) ? ax : bx;
		y1 = (ay > by) ? ay : by;
		x2 = (aex < bex) ? aex : bex;
		y2 = (aey < bey) ? aey : bey;
		iw = (x2 > x1) ? x2 - x1 : '0;
		ih = (y2 > y1) ? y2 - y1 : '0;
		lx = (ax < bx) ? ax : bx;
		ly = (ay < by) ? ay : by;
		rx = (aex > bex) ? aex : bex;
		ry = (aey > bey) ? aey : bey;
		a_empty = (item_q.box_w == '0) || (item_q.box_h == '0);
		b_empty = (rd_slot.box.w == '0) || (rd_slot.box.h == '0);
		if (a_empty) begin
			bwd = {1'b0, rd_slot.box.w};
			bhd = {1'b0, rd_slot.box.h};
		end else if (b_empty) begin
			bwd = {1'b0, item_q.box_w};
			bhd = {1'b0, item_q.box_h};
		end else begin
			bwd = rx - lx;
			bhd = ry - ly;
		end
		// centers in half pixels
		ca = {1'b0, item_q.box_x, 1'b0} + {2'b0, item_q.box_w};
		cb = {1'b0, rd_slot.box.x, 1'b0} + {2'b0, rd_slot.box.w};
		da = {1'b0, item_q.box_y, 1'b0} + {2'b0, item_q.box_h};
		db = {1'b0, rd_slot.box.y, 1'b0} + {2'b0, rd_slot.box.h};
	end

	// proximity trial and overlap divider step
	logic [15:0]     cand;
	logic [17:0]     r18;
	logic [16:0]     r17;
	logic [2*EW+1:0] rt;
	logic            fit;

	always_comb begin
		cand = p_q | (16'd1 << bit_q);
		r18  = 18'd65536 - {1'b0, cand, 1'b0};
		r17  = r18[16:0];
		fit  = ok_q && (prod_q <= {26'b0, rsq_q});
		rt   = (bit_q == 4'd15) ? {1'b0, rem_q} : {rem_q, 1'b0};
	end

	logic [15:0] ov_use;
	logic [32:0] score_sum;
	logic [17:0] score;

	assign ov_use    = (bound_q == '0) ? '0 : ov_q;
	assign score_sum = {1'b0, ovp_q} + {1'b0, pxp_q};
	assign score     = score_sum[32:15];

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= req_data;
		end
		if (cmd.geo1) begin
			iw_q <= iw;
			ih_q <= ih;
			bw_q <= bwd;
			bh_q <= bhd;
			dx_q <= (ca > cb) ? ca - cb : cb - ca;
			dy_q <= (da > db) ? da - db : db - da;
			cand_tn_q <= rd_slot.track_number;
		end
		if (cmd.geo2) begin
			inter_q <= iw_q * ih_q;
			bound_q <= bw_q * bh_q;
			dxsq_q  <= dx_q * dx_q;
			dysq_q  <= dy_q * dy_q;
		end
		if (cmd.srch_init) begin
			s_q   <= {1'b0, dxsq_q} + {1'b0, dysq_q};
			rem_q <= {1'b0, inter_q};
			ov_q  <= '0;
			p_q   <= '0;
			bit_q <= 4'd15;
		end
		if (cmd.mul1) begin
			ok_q  <= cand <= 16'd32768;
			psq_q <= cand * cand;
			rsq_q <= r17 * r17;
		end
		if (cmd.mul2) begin
			prod_q <= psq_q[30:0] * s_q;
		end
		if (cmd.decide) begin
			if (fit) begin
				p_q <= cand;
			end
			if (rt >= {2'b0, bound_q}) begin
				ov_q[bit_q] <= 1'b1;
				rem_q <= EW'(0) + (rt[2*EW:0] - {1'b0, bound_q});
			end else begin
				rem_q <= rt[2*EW:0];
			end
			bit_q <= bit_q - 4'd1;
		end
		if (cmd.sc1) begin
			ovp_q <= ow_q * ov_use;
			pxp_q <= pw_q * p_q;
		end
	end

	// table writes
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx_q;
		wr_slot = rd_slot;
		if (cmd.age_upd) begin
			ram_we = 1'b1;
			wr_slot.lost = (rd_slot.lost == 8'd255) ? 8'd255 : rd_slot.lost + 8'd1;
		end else if (cmd.commit) begin
			wr_slot.cls = item_q.object_class;
			wr_slot.box = {item_q.box_x, item_q.box_y, item_q.box_w, item_q.box_h};
			wr_slot.lost = '0;
			if (found_q) begin
				ram_we = 1'b1;
				ram_waddr = best_idx_q;
				wr_slot.track_number = best_tn_q;
			end else begin
				ram_we = free_found_q;
				ram_waddr = free_idx_q;
				wr_slot.track_number = next_id_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			valid_q <= '0;
			next_id_q <= 16'd1;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			removed_q <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				idx_q <= '0;
				found_q <= 1'b0;
				free_found_q <= 1'b0;
				best_q <= '0;
				removed_q <= '0;
			end else if (cmd.next) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.skip_free && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q <= idx_q;
			end
			if (cmd.sc2 && (score > {2'b0, thr_q}) && (score > best_q)) begin
				best_q <= score;
				best_idx_q <= idx_q;
				best_tn_q <= cand_tn_q;
				found_q <= 1'b1;
			end
			if (cmd.age_upd && (wr_slot.lost > limit_q)) begin
				valid_q[idx_q] <= 1'b0;
				if (removed_q != 7'd127) begin
					removed_q <= removed_q + 7'd1;
				end
			end
			if (cmd.commit) begin
				if (found_q) begin
					res_q <= '{track_number: best_tn_q, is_new: 1'b0, was_stored: 1'b1,
						removed_count: 7'd0};
				end else begin
					res_q <= '{track_number: next_id_q, is_new: 1'b1,
						was_stored: free_found_q, removed_count: 7'd0};
					next_id_q <= (next_id_q == 16'hFFFF) ? 16'd1 : next_id_q + 16'd1;
					if (free_found_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
				end
			end
			if (cmd.out_load) begin
				rsp_valid <= 1'b1;
				if (item_q.req_type) begin
					rsp_data <= '{track_number: 16'd0, is_new: 1'b0, was_stored: 1'b0,
						removed_count: removed_q};
				end else begin
					rsp_data <= res_q;
				end
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	assign stat.slot_valid = valid_q[idx_q];
	assign stat.slot_last  = idx_q == LAST_IDX;
	assign stat.class_hit  = rd_slot.cls == item_q.object_class;
	assign stat.iter_last  = bit_q == 4'd0;
	assign stat.out_free   = !rsp_valid || rsp_ready;

endmodule

// ===== src/iouct_checker.sv =====
// ----------------------------------------------------------------------------
// iouct_checker
// Port-level checks of the track matcher, bound to the top level.
// ----------------------------------------------------------------------------
module iouct_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input iouct_pkg::rsp_t rsp_data
);

	// one request in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response dropped or changed while stalled");

	// ID 0 only on end-of-frame responses
	a_eof_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.track_number == 16'd0) |-> !rsp_data.is_new && !rsp_data.was_stored)
		else $error("end-of-frame response carries detection flags");

	a_match_stored: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.is_new && (rsp_data.track_number != 16'd0)
			|-> rsp_data.was_stored)
		else $error("matched track reported as not stored");

	a_removed_eof: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.removed_count != 7'd0) |-> rsp_data.track_number == 16'd0)
		else $error("removal count on a detection response");

endmodule

bind iou_centroid_track_matcher_core iouct_checker u_iouct_checker (.*);
